// File: src/bfhp_pkg.sv
// ----------------------------------------------------------------------------
// bfhp_pkg
// Shared types and codes for the bit file header parser.
// ----------------------------------------------------------------------------
package bfhp_pkg;

    // parser phases
    localparam logic [3:0] PH_MLEN_HI = 4'd0;
    localparam logic [3:0] PH_MLEN_LO = 4'd1;
    localparam logic [3:0] PH_MAGIC   = 4'd2;
    localparam logic [3:0] PH_MEND    = 4'd3;
    localparam logic [3:0] PH_ONE_HI  = 4'd4;
    localparam logic [3:0] PH_ONE_LO  = 4'd5;
    localparam logic [3:0] PH_KEY     = 4'd6;
    localparam logic [3:0] PH_LEN_HI  = 4'd7;
    localparam logic [3:0] PH_LEN_LO  = 4'd8;
    localparam logic [3:0] PH_FIELD   = 4'd9;
    localparam logic [3:0] PH_BLEN    = 4'd10;
    localparam logic [3:0] PH_DONE    = 4'd11;
    localparam logic [3:0] PH_ERROR   = 4'd12;

    // status codes
    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_ONE_WORD  = 3'd2;
    localparam logic [2:0] ERR_KEY       = 3'd3;
    localparam logic [2:0] ERR_FIELD     = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd5;
    localparam logic [2:0] ERR_OVERSIZE  = 3'd6;

    // header constants
    localparam logic [7:0]  MAGIC_EVEN   = 8'h0f;
    localparam logic [7:0]  MAGIC_ODD    = 8'hf0;
    localparam logic [15:0] ONE_WORD     = 16'h0001;
    localparam logic [7:0]  KEY_FIRST    = 8'h61;
    localparam logic [2:0]  KEY_LAST_IDX = 3'd4;
    localparam logic [15:0] BLEN_BYTES   = 16'd4;

    typedef struct packed {
        logic       start_req;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] payload_bytes;
        logic [10:0] header_bytes;
        logic [2:0]  error_code;
        logic [1:0]  status;
    } result_t;

endpackage

// File: src/bfhp_in_reg.sv
// ----------------------------------------------------------------------------
// bfhp_in_reg
// Input register: holds one accepted byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module bfhp_in_reg
    import bfhp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    input  logic  item_take,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: src/bfhp_parse.sv
// ----------------------------------------------------------------------------
// bfhp_parse
// Header state and the per-byte next-state logic; gives the result of a byte.
// ----------------------------------------------------------------------------
module bfhp_parse
    import bfhp_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] file_length,
    input  logic        step,
    input  item_t       item,
    output result_t     result
);

    localparam int CNT_W = $clog2(MAX_HEADER_BYTES + 1);

    logic [3:0]       phase_reg,   phase_next,   phase_cur;
    logic [2:0]       sec_reg,     sec_next,     sec_cur;
    logic [15:0]      rem_reg,     rem_next,     rem_cur;
    logic             mpos_reg,    mpos_next,    mpos_cur;
    logic [CNT_W-1:0] cnt_reg,     cnt_next,     cnt_cur;
    logic [31:0]      acc_reg,     acc_next,     acc_cur;
    logic [7:0]       prev_reg,    prev_next,    prev_cur;
    logic [2:0]       fstat_reg,   fstat_next,   fstat_cur;

    logic [7:0]       b;
    logic [15:0]      word;
    logic [15:0]      rem_dec;
    logic [31:0]      acc_shift;
    logic [CNT_W-1:0] cnt_inc;
    logic [32:0]      total;
    logic [CNT_W+10:0] cnt_ext;

    assign b         = item.data_byte;
    assign word      = {prev_cur, b};
    assign rem_dec   = rem_cur - 16'd1;
    assign acc_shift = {acc_cur[23:0], b};
    assign cnt_inc   = cnt_cur + CNT_W'(1);
    assign total     = 33'(cnt_inc) + {1'b0, acc_shift};

    // restart values apply to the very byte that carries the start flag
    always_comb
    begin
        if (item.start_req)
        begin
            phase_cur = PH_MLEN_HI;
            sec_cur   = '0;
            rem_cur   = '0;
            mpos_cur  = 1'b0;
            cnt_cur   = '0;
            acc_cur   = '0;
            prev_cur  = '0;
            fstat_cur = ERR_NONE;
        end
        else
        begin
            phase_cur = phase_reg;
            sec_cur   = sec_reg;
            rem_cur   = rem_reg;
            mpos_cur  = mpos_reg;
            cnt_cur   = cnt_reg;
            acc_cur   = acc_reg;
            prev_cur  = prev_reg;
            fstat_cur = fstat_reg;
        end
    end

    always_comb
    begin
        phase_next = phase_cur;
        sec_next   = sec_cur;
        rem_next   = rem_cur;
        mpos_next  = mpos_cur;
        cnt_next   = cnt_cur;
        acc_next   = acc_cur;
        prev_next  = prev_cur;
        fstat_next = fstat_cur;

        if (phase_cur != PH_DONE && phase_cur != PH_ERROR)
        begin
            if (cnt_cur >= CNT_W'(MAX_HEADER_BYTES))
            begin
                phase_next = PH_ERROR;
                fstat_next = ERR_TOO_LONG;
            end
            else
            begin
                cnt_next = cnt_inc;
                case (phase_cur)
                    PH_MLEN_HI, PH_ONE_HI, PH_LEN_HI:
                    begin
                        prev_next  = b;
                        phase_next = phase_cur + 4'd1;
                    end
                    PH_MLEN_LO:
                    begin
                        if (word == 16'd0)
                        begin
                            phase_next = PH_ERROR;
                            fstat_next = ERR_MAGIC;
                        end
                        else
                        begin
                            rem_next   = word - 16'd1;
                            mpos_next  = 1'b0;
                            phase_next = (word != 16'd1) ? PH_MAGIC : PH_MEND;
                        end
                    end
                    PH_MAGIC:
                    begin
                        if (b != (mpos_cur ? MAGIC_ODD : MAGIC_EVEN))
                        begin
                            phase_next = PH_ERROR;
                            fstat_next = ERR_MAGIC;
                        end
                        else
                        begin
                            mpos_next = !mpos_cur;
                            rem_next  = rem_dec;
                            if (rem_dec == 16'd0)
                            begin
                                phase_next = PH_MEND;
                            end
                        end
                    end
                    PH_MEND:
                    begin
                        phase_next = PH_ONE_HI;
                    end
                    PH_ONE_LO:
                    begin
                        if (word != ONE_WORD)
                        begin
                            phase_next = PH_ERROR;
                            fstat_next = ERR_ONE_WORD;
                        end
                        else
                        begin
                            sec_next   = '0;
                            phase_next = PH_KEY;
                        end
                    end
                    PH_KEY:
                    begin
                        if (b != KEY_FIRST + {5'd0, sec_cur})
                        begin
                            phase_next = PH_ERROR;
                            fstat_next = ERR_KEY;
                        end
                        else if (sec_cur == KEY_LAST_IDX)
                        begin
                            rem_next   = BLEN_BYTES;
                            acc_next   = '0;
                            phase_next = PH_BLEN;
                        end
                        else
                        begin
                            phase_next = PH_LEN_HI;
                        end
                    end
                    PH_LEN_LO:
                    begin
                        if (word == 16'd0)
                        begin
                            phase_next = PH_ERROR;
                            fstat_next = ERR_FIELD;
                        end
                        else
                        begin
                            rem_next   = word;
                            phase_next = PH_FIELD;
                        end
                    end
                    PH_FIELD:
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == 16'd0)
                        begin
                            if (b != 8'd0)
                            begin
                                phase_next = PH_ERROR;
                                fstat_next = ERR_FIELD;
                            end
                            else
                            begin
                                sec_next   = sec_cur + 3'd1;
                                phase_next = PH_KEY;
                            end
                        end
                    end
                    PH_BLEN:
                    begin
                        acc_next = acc_shift;
                        rem_next = rem_dec;
                        if (rem_dec == 16'd0)
                        begin
                            if (total > {1'b0, file_length})
                            begin
                                phase_next = PH_ERROR;
                                fstat_next = ERR_OVERSIZE;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_ERROR;
                        fstat_next = ERR_MAGIC;
                    end
                endcase
            end
        end
    end

    assign cnt_ext = {11'd0, cnt_next};

    always_comb
    begin
        result = '0;
        if (phase_next == PH_DONE)
        begin
            result.status        = ST_DONE;
            result.header_bytes  = cnt_ext[10:0];
            result.payload_bytes = acc_next;
        end
        else if (phase_next == PH_ERROR)
        begin
            result.status     = ST_ERROR;
            result.error_code = fstat_next;
        end
        else
        begin
            result.status = ST_BUSY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MLEN_HI;
            sec_reg   <= '0;
            rem_reg   <= '0;
            mpos_reg  <= 1'b0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            prev_reg  <= '0;
            fstat_reg <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            sec_reg   <= sec_next;
            rem_reg   <= rem_next;
            mpos_reg  <= mpos_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            prev_reg  <= prev_next;
            fstat_reg <= fstat_next;
        end
    end

endmodule

// File: src/bfhp_out_reg.sv
// ----------------------------------------------------------------------------
// bfhp_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module bfhp_out_reg
    import bfhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_result,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // free when empty or when the held result leaves this cycle
    assign room       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

endmodule

// File: src/bit_file_header_parser.sv
// ----------------------------------------------------------------------------
// bit_file_header_parser
// Checks the header of a configuration bit file one byte at a time.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  s_axis    in         s_tvalid / s_tready         tdata: data_byte; tuser: start_req
//  m_axis    out        m_tvalid / m_tready         tdata: status, error_code,
//                                                   header_bytes, payload_bytes
//  config    in         cfg_wr_en                   cfg_wr_data: file_length
//
//  One byte is accepted per cycle while the result side does not stall;
//  each byte yields one result via input reg, parse logic and result reg.
//  The slowest path is the 33-bit header plus bitstream length compare.
//  Reset clears the parser to wait for the magic length and sets
//  file_length to all ones. A stalled result holds the parser; one more
//  byte is taken into the input register while it waits.
// ----------------------------------------------------------------------------
module bit_file_header_parser
    import bfhp_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [1:0] status, [4:2] error_code,
                                    // [15:5] header_bytes, [47:16] payload_bytes
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    logic [31:0] file_length_reg;
    item_t       in_item;
    item_t       item;
    logic        item_valid;
    logic        room;
    logic        step;
    result_t     result;
    result_t     out_result;

    assign in_item.data_byte = s_tdata;
    assign in_item.start_req = s_tuser;
    assign step              = item_valid && room;
    assign m_tdata           = out_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= 32'hffff_ffff;
        end
        else if (cfg_wr_en)
        begin
            file_length_reg <= cfg_wr_data;
        end
    end

    bfhp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (step),
        .item       (item)
    );

    bfhp_parse #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .file_length (file_length_reg),
        .step        (step),
        .item        (item),
        .result      (result)
    );

    bfhp_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step),
        .load_result (result),
        .room        (room),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

endmodule

// File: dv/bit_file_header_parser_tb.sv
// ----------------------------------------------------------------------------
// bit_file_header_parser_tb
// Streams bit file headers, well-formed and damaged, into the parser one byte
// per transfer. It predicts the status of every byte and compares each result
// transfer against it, under random gaps on both sides and one long output
// stall. The file length register is rewritten between phases.
// ----------------------------------------------------------------------------
module bit_file_header_parser_tb;
    import bfhp_pkg::*;

    localparam int MAX_HEADER   = 1024;
    localparam int RANDOM_BYTES = 240;
    localparam int LIMIT_CYCLES = 200000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        recv_hold     = 1'b0;
    int          cycles        = 0;
    logic [7:0]  file_q[$];

    // Tracks the parser state byte by byte and holds the statuses still due.
    class header_check;
        logic [31:0] file_len  = '1;
        logic [3:0]  stage     = PH_MLEN_HI;
        int unsigned key_idx   = 0;
        int unsigned left      = 0;
        int unsigned taken     = 0;
        bit          magic_odd = 1'b0;
        logic [31:0] blen_acc  = '0;
        logic [7:0]  held_byte = '0;
        logic [2:0]  err_code  = ERR_NONE;
        result_t     status_due[$];
        int          bad_results = 0;

        function void restart_parse();
            stage     = PH_MLEN_HI;
            key_idx   = 0;
            left      = 0;
            magic_odd = 1'b0;
            taken     = 0;
            blen_acc  = '0;
            held_byte = '0;
            err_code  = ERR_NONE;
        endfunction

        function void abort(logic [2:0] code);
            stage    = PH_ERROR;
            err_code = code;
        endfunction

        function void take_byte(logic [7:0] b, logic st);
            int unsigned len;
            result_t     r;
            if (st)
            begin
                restart_parse();
            end
            if (stage != PH_DONE && stage != PH_ERROR)
            begin
                if (taken >= MAX_HEADER)
                begin
                    abort(ERR_TOO_LONG);
                end
                else
                begin
                    taken++;
                    case (stage)
                        PH_MLEN_HI:
                        begin
                            held_byte = b;
                            stage     = PH_MLEN_LO;
                        end
                        PH_MLEN_LO:
                        begin
                            len = {held_byte, b};
                            if (len == 0)
                            begin
                                abort(ERR_MAGIC);
                            end
                            else
                            begin
                                left      = len - 1;
                                magic_odd = 1'b0;
                                stage     = (left != 0) ? PH_MAGIC : PH_MEND;
                            end
                        end
                        PH_MAGIC:
                        begin
                            if (b != (magic_odd ? MAGIC_ODD : MAGIC_EVEN))
                            begin
                                abort(ERR_MAGIC);
                            end
                            else
                            begin
                                magic_odd = !magic_odd;
                                left--;
                                if (left == 0)
                                begin
                                    stage = PH_MEND;
                                end
                            end
                        end
                        PH_MEND:
                        begin
                            stage = PH_ONE_HI;
                        end
                        PH_ONE_HI:
                        begin
                            held_byte = b;
                            stage     = PH_ONE_LO;
                        end
                        PH_ONE_LO:
                        begin
                            if ({held_byte, b} != ONE_WORD)
                            begin
                                abort(ERR_ONE_WORD);
                            end
                            else
                            begin
                                key_idx = 0;
                                stage   = PH_KEY;
                            end
                        end
                        PH_KEY:
                        begin
                            if (b != 8'(KEY_FIRST + key_idx))
                            begin
                                abort(ERR_KEY);
                            end
                            else if (key_idx == KEY_LAST_IDX)
                            begin
                                left     = BLEN_BYTES;
                                blen_acc = '0;
                                stage    = PH_BLEN;
                            end
                            else
                            begin
                                stage = PH_LEN_HI;
                            end
                        end
                        PH_LEN_HI:
                        begin
                            held_byte = b;
                            stage     = PH_LEN_LO;
                        end
                        PH_LEN_LO:
                        begin
                            len = {held_byte, b};
                            if (len == 0)
                            begin
                                abort(ERR_FIELD);
                            end
                            else
                            begin
                                left  = len;
                                stage = PH_FIELD;
                            end
                        end
                        PH_FIELD:
                        begin
                            left--;
                            if (left == 0)
                            begin
                                if (b != 8'h00)
                                begin
                                    abort(ERR_FIELD);
                                end
                                else
                                begin
                                    key_idx++;
                                    stage = PH_KEY;
                                end
                            end
                        end
                        PH_BLEN:
                        begin
                            blen_acc = {blen_acc[23:0], b};
                            left--;
                            if (left == 0)
                            begin
                                // compare without wrapping
                                if (64'(taken) + 64'(blen_acc) > 64'(file_len))
                                begin
                                    abort(ERR_OVERSIZE);
                                end
                                else
                                begin
                                    stage = PH_DONE;
                                end
                            end
                        end
                        default:
                        begin
                            abort(ERR_MAGIC);
                        end
                    endcase
                end
            end

            r = '0;
            if (stage == PH_DONE)
            begin
                r.status        = ST_DONE;
                r.error_code    = ERR_NONE;
                r.header_bytes  = 11'(taken);
                r.payload_bytes = blen_acc;
            end
            else if (stage == PH_ERROR)
            begin
                r.status     = ST_ERROR;
                r.error_code = err_code;
            end
            else
            begin
                r.status = ST_BUSY;
            end
            status_due.push_back(r);
        endfunction

        function void match_status(result_t got);
            result_t want;
            if (status_due.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                begin
                    $display("result transfer with nothing due: status %0d error %0d",
                             got.status, got.error_code);
                end
                return;
            end
            want = status_due.pop_front();
            if (got.status !== want.status || got.error_code !== want.error_code ||
                got.header_bytes !== want.header_bytes ||
                got.payload_bytes !== want.payload_bytes)
            begin
                bad_results++;
                if (bad_results <= 10)
                begin
                    $display("mismatch (expected/actual): status %0d/%0d error %0d/%0d",
                             want.status, got.status, want.error_code, got.error_code);
                    $display("    header_bytes %0d/%0d payload_bytes %0d/%0d",
                             want.header_bytes, got.header_bytes,
                             want.payload_bytes, got.payload_bytes);
                end
            end
        endfunction
    endclass

    header_check hdr = new;

    bit_file_header_parser #(
        .MAX_HEADER_BYTES (MAX_HEADER)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            hdr.match_status(result_t'(m_tdata));
        end
    end

    always @(negedge clk)
    begin
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold the output off; toggles recv_hold on the rising edge so the
    // receiver process sees a settled value.
    task automatic hold_receiver(input int n);
        @(posedge clk);
        recv_hold = 1'b1;
        repeat (n) @(posedge clk);
        recv_hold = 1'b0;
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic st);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = st;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        hdr.take_byte(b, st);
        @(negedge clk);
    endtask

    task automatic send_file(input logic with_start);
        foreach (file_q[i])
        begin
            send_byte(file_q[i], with_start && i == 0);
        end
    endtask

    // Bytes after done or error only repeat the held status.
    task automatic send_trailing(input int n);
        repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (hdr.status_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(negedge clk);
    endtask

    task automatic write_file_length(input logic [31:0] v);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en    = 1'b0;
        hdr.file_len = v;
    endtask

    // Header length comes to 21 + mlen + sum of the field lengths.
    function automatic void make_header(int mlen, int flen[4], logic [31:0] blen);
        file_q.delete();
        file_q.push_back(mlen[15:8]);
        file_q.push_back(mlen[7:0]);
        for (int k = 1; k < mlen; k++)
        begin
            file_q.push_back(k[0] ? MAGIC_EVEN : MAGIC_ODD);
        end
        file_q.push_back(8'($urandom_range(255)));
        file_q.push_back(ONE_WORD[15:8]);
        file_q.push_back(ONE_WORD[7:0]);
        for (int s = 0; s < 4; s++)
        begin
            file_q.push_back(8'(KEY_FIRST + s));
            file_q.push_back(flen[s][15:8]);
            file_q.push_back(flen[s][7:0]);
            for (int j = 1; j < flen[s]; j++)
            begin
                file_q.push_back(8'($urandom_range(255)));
            end
            file_q.push_back(8'h00);
        end
        file_q.push_back(8'(KEY_FIRST + KEY_LAST_IDX));
        file_q.push_back(blen[31:24]);
        file_q.push_back(blen[23:16]);
        file_q.push_back(blen[15:8]);
        file_q.push_back(blen[7:0]);
    endfunction

    task automatic run_directed();
        // clean header straight after reset, no start flag
        make_header(9, '{3, 2, 4, 1}, 32'd1000);
        send_file(1'b0);
        send_trailing(2);

        // zero magic length
        file_q = '{8'h00, 8'h00, 8'h0f};
        send_file(1'b1);

        // magic length of one goes straight to the end byte; empty bitstream
        make_header(1, '{1, 1, 1, 1}, 32'd0);
        send_file(1'b1);
        send_trailing(1);

        // broken magic pattern
        make_header(5, '{1, 2, 1, 2}, 32'd7);
        file_q[3] = 8'h0f;
        send_file(1'b1);

        // bad 0x0001 word
        make_header(3, '{1, 1, 1, 1}, 32'd7);
        file_q[6] = 8'h02;
        send_file(1'b1);

        // wrong key
        make_header(5, '{1, 1, 1, 1}, 32'd7);
        file_q[9] = 8'h62;
        send_file(1'b1);

        // zero field length
        make_header(3, '{2, 1, 1, 1}, 32'd7);
        file_q[8] = 8'h00;
        file_q[9] = 8'h00;
        send_file(1'b1);

        // field without a closing zero
        make_header(3, '{1, 1, 1, 1}, 32'd7);
        file_q[10] = 8'hff;
        send_file(1'b1);

        // bitstream length too large for the file
        make_header(3, '{1, 1, 1, 1}, 32'hffff_ffff);
        send_file(1'b1);
        send_trailing(2);

        // restart in the middle of a file
        make_header(7, '{2, 2, 2, 2}, 32'd9);
        for (int i = 0; i < 6; i++)
        begin
            send_byte(file_q[i], i == 0);
        end
        send_file(1'b1);

        // largest magic length runs past the maximum header length
        file_q = '{8'hff, 8'hff};
        for (int k = 1; k <= MAX_HEADER - 1; k++)
        begin
            file_q.push_back(k[0] ? MAGIC_EVEN : MAGIC_ODD);
        end
        send_file(1'b1);
        send_trailing(1);

        // header of 33 bytes plus 100: exact fit, one short, then no room at all
        make_header(4, '{2, 2, 2, 2}, 32'd100);
        wait_drained();
        write_file_length(32'd133);
        send_file(1'b1);
        wait_drained();
        write_file_length(32'd132);
        send_file(1'b1);
        wait_drained();
        write_file_length(32'd0);
        send_file(1'b1);
    endtask

    task automatic send_random_file(output int n);
        int          kind;
        int          mlen;
        int          flen[4];
        logic [31:0] blen;
        kind = $urandom_range(99);
        if (kind < 5)
        begin
            // noise
            file_q.delete();
            repeat ($urandom_range(1, 20)) file_q.push_back(8'($urandom_range(255)));
        end
        else
        begin
            mlen = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 13);
            for (int s = 0; s < 4; s++)
            begin
                if ($urandom_range(199) == 0)
                begin
                    flen[s] = $urandom_range(200, 1100);
                end
                else if ($urandom_range(7) == 0)
                begin
                    flen[s] = $urandom_range(9, 40);
                end
                else
                begin
                    flen[s] = $urandom_range(1, 8);
                end
            end
            blen = $urandom_range(1) ? 32'($urandom_range(0, 400)) : 32'($urandom);
            make_header(mlen, flen, blen);
            if (kind >= 75 && kind < 92)
            begin
                file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom_range(255));
            end
            else if (kind >= 92)
            begin
                file_q = file_q[0:$urandom_range(file_q.size() - 1)];
            end
        end
        n = file_q.size();
        send_file($urandom_range(9) != 0);
        send_trailing($urandom_range(3));
    endtask

    task automatic run_random();
        int sent;
        int n;
        for (int blk = 0; blk < 6; blk++)
        begin
            if (blk == 2)
            begin
                set_idle(47, 16);
            end
            else if (blk == 4)
            begin
                set_idle(0, 0);
            end
            wait_drained();
            if (blk == 0)
            begin
                write_file_length(32'hffff_ffff);
            end
            else if (blk == 5)
            begin
                write_file_length(32'($urandom));
            end
            else
            begin
                write_file_length(32'($urandom_range(30, 500)));
            end
            // long output stall while bytes keep coming: fills the pipe
            if (blk == 1)
            begin
                fork
                    hold_receiver(400);
                join_none
            end
            sent = 0;
            while (sent < RANDOM_BYTES / 6)
            begin
                send_random_file(n);
                sent += n;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        set_idle(16, 47);
        run_directed();
        run_random();
        wait_drained();
        if (hdr.bad_results == 0 && hdr.status_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
